/* src/tlis_pkg.sv */
// Package: shared constants and types for the two-line inlier search.
package tlis_pkg;

  localparam int MaxPointsDefault = 64;
  localparam int CoordBitsDefault = 12;
  localparam logic [7:0] RadiusReset = 8'd20;

  // Register map (byte addresses)
  localparam logic [1:0] AddrRadius = 2'd0;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_FETCH_I,
    ST_FETCH_J,
    ST_FETCH_K,
    ST_TEST,
    ST_MUL1,
    ST_MUL2,
    ST_DECIDE,
    ST_PAIR_END,
    ST_OUT
  } seq_state_t;

  // Test unit status back to the sequencer
  typedef struct packed {
    logic inlier;
  } unit_status_t;

endpackage

/* src/tlis_test_unit.sv */
// Shared distance test unit: one step per cycle as chosen by step, over three steps.
module tlis_test_unit #(
  parameter int CoordBits = tlis_pkg::CoordBitsDefault
) (
  input  logic                 clk,
  input  logic [1:0]           step,
  input  logic [CoordBits-1:0] xi,
  input  logic [CoordBits-1:0] yi,
  input  logic [CoordBits-1:0] xj,
  input  logic [CoordBits-1:0] yj,
  input  logic [CoordBits-1:0] xk,
  input  logic [CoordBits-1:0] yk,
  input  logic [7:0]           radius,
  output tlis_pkg::unit_status_t status
);

  localparam int DW = CoordBits + 1;
  localparam int PW = 2 * DW;
  localparam int NW = PW + 1;
  localparam int LW = PW + 1;
  localparam int RW = 2 * 9;

  logic signed [DW-1:0] a, b, dx, dy;
  logic signed [PW-1:0] p0, p1;
  logic signed [NW-1:0] n;
  logic        [NW-1:0] mag;
  logic        [LW-1:0] len2;
  logic        [2*NW-1:0] lhs;
  logic        [RW-1:0] r2;
  logic        [RW+LW-1:0] rhs;

  assign a  = $signed({1'b0, xj}) - $signed({1'b0, xi});
  assign b  = $signed({1'b0, yj}) - $signed({1'b0, yi});
  assign dx = $signed({1'b0, xk}) - $signed({1'b0, xi});
  assign dy = $signed({1'b0, yk}) - $signed({1'b0, yi});

  // Step 0: cross products and squares; step 1: their products; step 2: final compare
  always_ff @(posedge clk) begin
    case (step)
      2'd0: begin
        p0 <= a * dy;
        p1 <= b * dx;
        len2 <= LW'(unsigned'(PW'(a * a))) + LW'(unsigned'(PW'(b * b)));
        r2 <= RW'((9'({1'b0, radius}) + 9'd1) * (9'({1'b0, radius}) + 9'd1));
      end
      2'd1: begin
        lhs <= mag * mag;
        rhs <= RW'(r2) * len2;
      end
      default: ;
    endcase
  end

  assign n   = NW'(p0) - NW'(p1);
  assign mag = n[NW-1] ? NW'(-n) : n;
  assign status.inlier = (2*NW + 1)'(lhs) < (2*NW + 1)'(rhs);

endmodule

/* src/two_line_inlier_search.sv */
// Top level: point store, search sequencer and APB register.
// Loading: a point is taken whenever start is high and busy is low. A pair (i, j)
// tests every point k in turn; line two skips points marked as line one's inliers.
// Line one, an inlier marking pass if line one was found, then line two run from the
// last point to the result strobe (fewer than two points go straight to it); busy is
// high meanwhile. Synchronous active-high reset; radius resets to 20, store not cleared.
module two_line_inlier_search #(
  parameter int MaxPoints = tlis_pkg::MaxPointsDefault,
  parameter int CoordBits = tlis_pkg::CoordBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 start,
  output logic                 busy,
  input  logic [CoordBits-1:0] point_x,
  input  logic [CoordBits-1:0] point_y,
  input  logic                 last_point,
  output logic                 done,
  output logic [5:0]           first_start,
  output logic [5:0]           first_end,
  output logic [6:0]           first_count,
  output logic                 first_found,
  output logic [5:0]           second_start,
  output logic [5:0]           second_end,
  output logic [6:0]           second_count,
  output logic                 second_found,
  output logic                 dropped
);

  localparam int IW = (MaxPoints > 2) ? $clog2(MaxPoints) : 1;
  localparam int CW = $clog2(MaxPoints + 1);

  tlis_pkg::seq_state_t state, state_next;
  tlis_pkg::unit_status_t ustat;

  logic [7:0]  radius;
  logic [CW-1:0] count;
  logic        overflow;
  logic        second;   // line two pass
  logic        marking;  // marking pass for line one's inliers
  logic [MaxPoints-1:0] mask;
  logic [IW-1:0] i, j, k, bs, be;
  logic [CW-1:0] cnt, bc;
  logic        found;
  logic [IW-1:0] rd_addr;
  logic [2*CoordBits-1:0] mem [MaxPoints];
  logic [2*CoordBits-1:0] rd_data, pi, pj;
  logic [1:0]  step;
  logic        accept;
  logic        k_last, j_last, i_last;
  logic        skip_i, take, found_fin;
  logic [IW-1:0] bs_fin, be_fin;
  logic [CW-1:0] bc_fin;

  // Register port
  assign pready = 1'b1;
  assign prdata = {24'd0, radius};
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= tlis_pkg::RadiusReset;
    end else if (psel && penable && pwrite && paddr == tlis_pkg::AddrRadius) begin
      radius <= pwdata[7:0];
    end
  end

  assign accept = start && !busy;
  assign busy   = (state != tlis_pkg::ST_LOAD);

  // Point store, registered read
  always_ff @(posedge clk) begin
    if (accept && count < CW'(MaxPoints)) begin
      mem[count[IW-1:0]] <= {point_y, point_x};
    end
    rd_data <= mem[rd_addr];
  end

  // Loop ends
  assign k_last = ((CW+1)'(k) + (CW+1)'(1)) >= (CW+1)'(count);
  assign j_last = ((CW+1)'(j) + (CW+1)'(1)) >= (CW+1)'(count);
  assign i_last = ((CW+1)'(i) + (CW+1)'(2)) >= (CW+1)'(count);

  // Read address: i is also re-read before each new j so pi reloads cleanly
  always_comb begin
    case (state)
      tlis_pkg::ST_FETCH_I:  rd_addr = i;
      tlis_pkg::ST_FETCH_J:  rd_addr = j;
      tlis_pkg::ST_PAIR_END: rd_addr = i;
      default:               rd_addr = k;
    endcase
  end

  // Point k goes straight from the store read register into the unit
  tlis_test_unit #(.CoordBits(CoordBits)) u_test (
    .clk(clk), .step(step),
    .xi(pi[CoordBits-1:0]), .yi(pi[2*CoordBits-1:CoordBits]),
    .xj(pj[CoordBits-1:0]), .yj(pj[2*CoordBits-1:CoordBits]),
    .xk(rd_data[CoordBits-1:0]), .yk(rd_data[2*CoordBits-1:CoordBits]),
    .radius(radius), .status(ustat)
  );

  // Unit step select
  always_comb begin
    case (state)
      tlis_pkg::ST_TEST: step = 2'd0;
      tlis_pkg::ST_MUL1: step = 2'd1;
      default:           step = 2'd2;
    endcase
  end

  // Best pair including the pair being closed this cycle
  assign skip_i    = second && mask[i];
  assign take      = !marking && !skip_i && cnt > bc;
  assign bs_fin    = take ? i : bs;
  assign be_fin    = take ? j : be;
  assign bc_fin    = take ? cnt : bc;
  assign found_fin = take | found;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      tlis_pkg::ST_LOAD: begin
        if (accept && last_point) begin
          state_next = (count + CW'(count < CW'(MaxPoints)) >= CW'(2))
                       ? tlis_pkg::ST_FETCH_I : tlis_pkg::ST_OUT;
        end
      end
      tlis_pkg::ST_FETCH_I:
        state_next = skip_i ? tlis_pkg::ST_PAIR_END : tlis_pkg::ST_FETCH_J;
      tlis_pkg::ST_FETCH_J: state_next = tlis_pkg::ST_FETCH_K;
      tlis_pkg::ST_FETCH_K:
        state_next = (second && mask[k]) ? tlis_pkg::ST_DECIDE : tlis_pkg::ST_TEST;
      tlis_pkg::ST_TEST:  state_next = tlis_pkg::ST_MUL1;
      tlis_pkg::ST_MUL1:  state_next = tlis_pkg::ST_MUL2;
      tlis_pkg::ST_MUL2:  state_next = tlis_pkg::ST_DECIDE;
      tlis_pkg::ST_DECIDE:
        state_next = k_last ? tlis_pkg::ST_PAIR_END : tlis_pkg::ST_FETCH_K;
      tlis_pkg::ST_PAIR_END: begin
        if (!marking && !skip_i && !j_last) begin
          state_next = tlis_pkg::ST_FETCH_J;
        end else if (marking || !i_last || !second) begin
          state_next = tlis_pkg::ST_FETCH_I;
        end else begin
          state_next = tlis_pkg::ST_OUT;
        end
      end
      tlis_pkg::ST_OUT:   state_next = tlis_pkg::ST_LOAD;
      default:            state_next = tlis_pkg::ST_LOAD;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tlis_pkg::ST_LOAD;
      count    <= '0;
      overflow <= 1'b0;
      done     <= 1'b0;
      dropped  <= 1'b0;
      second   <= 1'b0;
      marking  <= 1'b0;
      mask     <= '0;
    end else begin
      state <= state_next;
      done  <= (state == tlis_pkg::ST_OUT);
      case (state)
        tlis_pkg::ST_LOAD:
          if (accept) begin
            if (count < CW'(MaxPoints)) count <= count + CW'(1);
            else overflow <= 1'b1;
            if (last_point) begin
              i <= '0; k <= '0;
              bs <= '0; be <= '0; bc <= '0; found <= 1'b0;
              second <= 1'b0; marking <= 1'b0; mask <= '0;
              first_start <= '0; first_end <= '0; first_count <= '0;
              first_found <= 1'b0;
              second_start <= '0; second_end <= '0; second_count <= '0;
              second_found <= 1'b0;
            end
          end
        tlis_pkg::ST_FETCH_I: begin
          if (!marking) j <= i + IW'(1);
        end
        tlis_pkg::ST_FETCH_J: begin
          pi <= rd_data; k <= '0; cnt <= '0;
        end
        tlis_pkg::ST_FETCH_K: begin
          if (k == '0) pj <= rd_data;
        end
        tlis_pkg::ST_DECIDE: begin
          if (marking) mask[k] <= ustat.inlier;
          else if (!(second && mask[k]) && ustat.inlier) cnt <= cnt + CW'(1);
          k <= k + IW'(1);
        end
        tlis_pkg::ST_PAIR_END: begin
          k <= '0;
          if (marking) begin
            // line one marked: start line two
            marking <= 1'b0; second <= 1'b1; i <= '0;
            bs <= '0; be <= '0; bc <= '0; found <= 1'b0;
          end else if (!skip_i && !j_last) begin
            if (take) begin
              bs <= i; be <= j; bc <= cnt; found <= 1'b1;
            end
            j <= j + IW'(1);
          end else if (!i_last) begin
            if (take) begin
              bs <= i; be <= j; bc <= cnt; found <= 1'b1;
            end
            i <= i + IW'(1);
          end else if (!second) begin
            first_start <= 6'(bs_fin); first_end <= 6'(be_fin);
            first_count <= 7'(bc_fin); first_found <= found_fin;
            if (found_fin) begin
              marking <= 1'b1; i <= bs_fin; j <= be_fin;
            end else begin
              second <= 1'b1; i <= '0;
            end
            bs <= '0; be <= '0; bc <= '0; found <= 1'b0;
          end else begin
            second_start <= 6'(bs_fin); second_end <= 6'(be_fin);
            second_count <= 7'(bc_fin); second_found <= found_fin;
          end
        end
        tlis_pkg::ST_OUT: begin
          dropped  <= overflow;
          count    <= '0;
          overflow <= 1'b0;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while busy");
  a_one_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MaxPoints)) else $error("point count beyond capacity");
`endif

endmodule
